/* src/rv32enc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RV32IM encoder package
// Shared types, opcodes, mnemonic codes and status codes of the encoder.
// ----------------------------------------------------------------------------
package rv32enc_pkg;

  // Base opcodes
  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;

  // funct7 values
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [6:0] F7_MUL  = 7'b0000001;

  // Largest legal shift amount
  localparam logic [31:0] SHAMT_MAX = 32'd31;

  // Instruction formats; SH is the shift-immediate flavor of I
  typedef enum logic [2:0] {
    FMT_R  = 3'd0,
    FMT_I  = 3'd1,
    FMT_S  = 3'd2,
    FMT_B  = 3'd3,
    FMT_U  = 3'd4,
    FMT_J  = 3'd5,
    FMT_SH = 3'd6
  } fmt_t;

  // Mnemonic codes on the input channel
  typedef enum logic [5:0] {
    ACT_ADD    = 6'd0,  ACT_SUB    = 6'd1,  ACT_SLL    = 6'd2,  ACT_SLT    = 6'd3,
    ACT_SLTU   = 6'd4,  ACT_XOR    = 6'd5,  ACT_SRL    = 6'd6,  ACT_SRA    = 6'd7,
    ACT_OR     = 6'd8,  ACT_AND    = 6'd9,  ACT_ADDI   = 6'd10, ACT_SLTI   = 6'd11,
    ACT_SLTIU  = 6'd12, ACT_XORI   = 6'd13, ACT_ORI    = 6'd14, ACT_ANDI   = 6'd15,
    ACT_SLLI   = 6'd16, ACT_SRLI   = 6'd17, ACT_SRAI   = 6'd18, ACT_LB     = 6'd19,
    ACT_LH     = 6'd20, ACT_LW     = 6'd21, ACT_LBU    = 6'd22, ACT_LHU    = 6'd23,
    ACT_JALR   = 6'd24, ACT_SB     = 6'd25, ACT_SH     = 6'd26, ACT_SW     = 6'd27,
    ACT_BEQ    = 6'd28, ACT_BNE    = 6'd29, ACT_BLT    = 6'd30, ACT_BGE    = 6'd31,
    ACT_BLTU   = 6'd32, ACT_BGEU   = 6'd33, ACT_LUI    = 6'd34, ACT_AUIPC  = 6'd35,
    ACT_JAL    = 6'd36, ACT_MUL    = 6'd37, ACT_MULH   = 6'd38, ACT_MULHSU = 6'd39,
    ACT_MULHU  = 6'd40, ACT_DIV    = 6'd41, ACT_DIVU   = 6'd42, ACT_REM    = 6'd43,
    ACT_REMU   = 6'd44
  } mnem_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_SHAMT   = 2'd2,
    ST_ODD     = 2'd3
  } status_t;

  // Decoded row handed from the decoder to the packer
  typedef struct packed {
    logic       known;
    logic [6:0] opcode;
    logic [2:0] f3;
    logic [6:0] f7;
    fmt_t       fmt;
  } enc_row_t;

endpackage : rv32enc_pkg
`default_nettype wire

/* src/rv32enc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RV32IM encoder channels
// Valid/ready channel interfaces for instruction requests and encoded words.
// ----------------------------------------------------------------------------
interface rv32enc_in_if;
  logic               valid;
  logic               ready;
  logic        [5:0]  action;
  logic        [4:0]  rd;
  logic        [4:0]  rs1;
  logic        [4:0]  rs2;
  logic signed [31:0] imm;
  logic        [31:0] inst_addr;
  logic        [31:0] dest_addr;

  modport source (output valid, action, rd, rs1, rs2, imm, inst_addr,
                  dest_addr, input ready);
  modport sink   (input valid, action, rd, rs1, rs2, imm, inst_addr,
                  dest_addr, output ready);
endinterface : rv32enc_in_if

interface rv32enc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic [1:0]  status;

  modport source (output valid, word, status, input ready);
  modport sink   (input valid, word, status, output ready);
endinterface : rv32enc_out_if
`default_nettype wire

/* src/rv32im_instruction_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// Path: a request is captured in the input register, then in the result
//   register; decode and bit packing sit between the two.
// Throughput: one transaction per cycle while the result side keeps taking.
// Reset: rst_n (synchronous, active low) clears both stage valid flags;
//   the payload and result registers are not reset.
// ----------------------------------------------------------------------------
// RV32IM instruction encoder
// Two-stage valid/ready pipeline that turns one mnemonic request into one
// 32-bit RV32IM machine word plus a status code.
// ----------------------------------------------------------------------------
module rv32im_instruction_encoder
  import rv32enc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  rv32enc_in_if.sink   in_ch,
  rv32enc_out_if.source out_ch
);

  // Stage 1: input register
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [5:0]  action_r;
  logic [4:0]  rd_r;
  logic [4:0]  rs1_r;
  logic [4:0]  rs2_r;
  logic [31:0] imm_r;
  logic [31:0] cur_r;
  logic [31:0] tgt_r;

  // Stage 2: result register
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] word_r;
  logic [1:0]  status_r;

  // Handshake
  logic     s2_ready;
  logic     s1_ready;
  logic     in_take;
  logic     s1_move;

  // Datapath between the two registers
  enc_row_t row;
  logic [31:0] word_nxt;
  status_t     status_nxt;

  // The result register frees up when empty or when its transaction leaves;
  // the input register frees up when empty or when it can advance.
  assign s2_ready = !out_valid_r || out_ch.ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_take  = in_ch.valid && s1_ready;
  assign s1_move  = s1_valid_r && s2_ready;

  assign in_ch.ready = s1_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_ready) begin
      s1_valid_nxt = in_ch.valid;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_ready) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the request payload on an accepted transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      action_r <= in_ch.action;
      rd_r     <= in_ch.rd;
      rs1_r    <= in_ch.rs1;
      rs2_r    <= in_ch.rs2;
      imm_r    <= in_ch.imm;
      cur_r    <= in_ch.inst_addr;
      tgt_r    <= in_ch.dest_addr;
    end
  end

  // Look up opcode, funct fields and format
  rv32enc_decode u_decode (
    .action (action_r),
    .row    (row)
  );

  // Pack fields and flag shift-range and odd-offset errors
  rv32enc_pack u_pack (
    .row       (row),
    .rd        (rd_r),
    .rs1       (rs1_r),
    .rs2       (rs2_r),
    .imm       (imm_r),
    .inst_addr (cur_r),
    .dest_addr (tgt_r),
    .word      (word_nxt),
    .status    (status_nxt)
  );

  // Advance the encoded word into the result register
  always_ff @(posedge clk) begin
    if (s1_move) begin
      word_r   <= word_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.word   = word_r;
  assign out_ch.status = status_r;

endmodule : rv32im_instruction_encoder
`default_nettype wire

/* src/rv32enc_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RV32IM encoder mnemonic decoder
// Map a mnemonic code to opcode, funct3, funct7 and instruction format.
// ----------------------------------------------------------------------------
module rv32enc_decode
  import rv32enc_pkg::*;
(
  input  wire logic [5:0] action,
  output enc_row_t        row
);

  always_comb begin
    row = '{known: 1'b1, opcode: OP_REG, f3: 3'd0, f7: F7_BASE, fmt: FMT_R};
    case (mnem_t'(action))
      ACT_ADD:    row = '{1'b1, OP_REG,    3'd0, F7_BASE, FMT_R};
      ACT_SUB:    row = '{1'b1, OP_REG,    3'd0, F7_ALT,  FMT_R};
      ACT_SLL:    row = '{1'b1, OP_REG,    3'd1, F7_BASE, FMT_R};
      ACT_SLT:    row = '{1'b1, OP_REG,    3'd2, F7_BASE, FMT_R};
      ACT_SLTU:   row = '{1'b1, OP_REG,    3'd3, F7_BASE, FMT_R};
      ACT_XOR:    row = '{1'b1, OP_REG,    3'd4, F7_BASE, FMT_R};
      ACT_SRL:    row = '{1'b1, OP_REG,    3'd5, F7_BASE, FMT_R};
      ACT_SRA:    row = '{1'b1, OP_REG,    3'd5, F7_ALT,  FMT_R};
      ACT_OR:     row = '{1'b1, OP_REG,    3'd6, F7_BASE, FMT_R};
      ACT_AND:    row = '{1'b1, OP_REG,    3'd7, F7_BASE, FMT_R};
      ACT_ADDI:   row = '{1'b1, OP_IMM,    3'd0, F7_BASE, FMT_I};
      ACT_SLTI:   row = '{1'b1, OP_IMM,    3'd2, F7_BASE, FMT_I};
      ACT_SLTIU:  row = '{1'b1, OP_IMM,    3'd3, F7_BASE, FMT_I};
      ACT_XORI:   row = '{1'b1, OP_IMM,    3'd4, F7_BASE, FMT_I};
      ACT_ORI:    row = '{1'b1, OP_IMM,    3'd6, F7_BASE, FMT_I};
      ACT_ANDI:   row = '{1'b1, OP_IMM,    3'd7, F7_BASE, FMT_I};
      ACT_SLLI:   row = '{1'b1, OP_IMM,    3'd1, F7_BASE, FMT_SH};
      ACT_SRLI:   row = '{1'b1, OP_IMM,    3'd5, F7_BASE, FMT_SH};
      ACT_SRAI:   row = '{1'b1, OP_IMM,    3'd5, F7_ALT,  FMT_SH};
      ACT_LB:     row = '{1'b1, OP_LOAD,   3'd0, F7_BASE, FMT_I};
      ACT_LH:     row = '{1'b1, OP_LOAD,   3'd1, F7_BASE, FMT_I};
      ACT_LW:     row = '{1'b1, OP_LOAD,   3'd2, F7_BASE, FMT_I};
      ACT_LBU:    row = '{1'b1, OP_LOAD,   3'd4, F7_BASE, FMT_I};
      ACT_LHU:    row = '{1'b1, OP_LOAD,   3'd5, F7_BASE, FMT_I};
      ACT_JALR:   row = '{1'b1, OP_JALR,   3'd0, F7_BASE, FMT_I};
      ACT_SB:     row = '{1'b1, OP_STORE,  3'd0, F7_BASE, FMT_S};
      ACT_SH:     row = '{1'b1, OP_STORE,  3'd1, F7_BASE, FMT_S};
      ACT_SW:     row = '{1'b1, OP_STORE,  3'd2, F7_BASE, FMT_S};
      ACT_BEQ:    row = '{1'b1, OP_BRANCH, 3'd0, F7_BASE, FMT_B};
      ACT_BNE:    row = '{1'b1, OP_BRANCH, 3'd1, F7_BASE, FMT_B};
      ACT_BLT:    row = '{1'b1, OP_BRANCH, 3'd4, F7_BASE, FMT_B};
      ACT_BGE:    row = '{1'b1, OP_BRANCH, 3'd5, F7_BASE, FMT_B};
      ACT_BLTU:   row = '{1'b1, OP_BRANCH, 3'd6, F7_BASE, FMT_B};
      ACT_BGEU:   row = '{1'b1, OP_BRANCH, 3'd7, F7_BASE, FMT_B};
      ACT_LUI:    row = '{1'b1, OP_LUI,    3'd0, F7_BASE, FMT_U};
      ACT_AUIPC:  row = '{1'b1, OP_AUIPC,  3'd0, F7_BASE, FMT_U};
      ACT_JAL:    row = '{1'b1, OP_JAL,    3'd0, F7_BASE, FMT_J};
      ACT_MUL:    row = '{1'b1, OP_REG,    3'd0, F7_MUL,  FMT_R};
      ACT_MULH:   row = '{1'b1, OP_REG,    3'd1, F7_MUL,  FMT_R};
      ACT_MULHSU: row = '{1'b1, OP_REG,    3'd2, F7_MUL,  FMT_R};
      ACT_MULHU:  row = '{1'b1, OP_REG,    3'd3, F7_MUL,  FMT_R};
      ACT_DIV:    row = '{1'b1, OP_REG,    3'd4, F7_MUL,  FMT_R};
      ACT_DIVU:   row = '{1'b1, OP_REG,    3'd5, F7_MUL,  FMT_R};
      ACT_REM:    row = '{1'b1, OP_REG,    3'd6, F7_MUL,  FMT_R};
      ACT_REMU:   row = '{1'b1, OP_REG,    3'd7, F7_MUL,  FMT_R};
      default:    row = '{1'b0, OP_REG,    3'd0, F7_BASE, FMT_R};
    endcase
  end

endmodule : rv32enc_decode
`default_nettype wire

/* src/rv32enc_pack.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RV32IM encoder word packer
// Place register numbers, immediates and offsets into the selected format.
// ----------------------------------------------------------------------------
module rv32enc_pack
  import rv32enc_pkg::*;
(
  input  wire enc_row_t      row,
  input  wire logic   [4:0]  rd,
  input  wire logic   [4:0]  rs1,
  input  wire logic   [4:0]  rs2,
  input  wire logic   [31:0] imm,
  input  wire logic   [31:0] inst_addr,
  input  wire logic   [31:0] dest_addr,
  output logic        [31:0] word,
  output status_t            status
);

  logic [31:0] off;

  assign off = dest_addr - inst_addr;

  always_comb begin
    word   = '0;
    status = ST_OK;
    if (!row.known) begin
      status = ST_UNKNOWN;
    end else begin
      case (row.fmt)
        FMT_R: begin
          word = {row.f7, rs2, rs1, row.f3, rd, row.opcode};
        end
        FMT_I: begin
          word = {imm[11:0], rs1, row.f3, rd, row.opcode};
        end
        FMT_SH: begin
          // unsigned compare: negative amounts fail too
          if (imm > SHAMT_MAX) begin
            status = ST_SHAMT;
          end else begin
            word = {row.f7, imm[4:0], rs1, row.f3, rd, row.opcode};
          end
        end
        FMT_S: begin
          word = {imm[11:5], rs2, rs1, row.f3, imm[4:0], row.opcode};
        end
        FMT_B: begin
          if (off[0]) begin
            status = ST_ODD;
          end else begin
            word = {off[12], off[10:5], rs2, rs1, row.f3, off[4:1], off[11], row.opcode};
          end
        end
        FMT_U: begin
          word = {imm[19:0], rd, row.opcode};
        end
        FMT_J: begin
          if (off[0]) begin
            status = ST_ODD;
          end else begin
            word = {off[20], off[10:1], off[11], off[19:12], rd, row.opcode};
          end
        end
        default: begin
          word   = '0;
          status = ST_UNKNOWN;
        end
      endcase
    end
  end

endmodule : rv32enc_pack
`default_nettype wire
